// File: hw/rtl/lpht_pkg.sv
package lpht_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int MAX_KEY_LEN = 32;
  localparam int IDX_W       = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int LEN_W       = $clog2(MAX_KEY_LEN + 2);
  localparam int VALUE_W     = 32;
  localparam int HASH_W      = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [HASH_W-1:0] GOLDEN_FRAC = 32'h9E3779B9;

  typedef enum logic [1:0] {
    OP_PUT     = 2'd0,
    OP_GET     = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_DISCARD = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_TOO_LONG   = 2'd3
  } status_t;

  typedef logic [MAX_KEY_LEN-1:0][7:0] key_t;

  typedef struct packed {
    opcode_t             op;
    logic [LEN_W-1:0]    len;
    logic                too_long;
    logic [HASH_W-1:0]   acc;
    logic [VALUE_W-1:0]  value;
    key_t                key;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HASH,
    BK_PROBE,
    BK_LEN_CHK,
    BK_BYTE_CHK,
    BK_BYTE_WAIT,
    BK_WRITE
  } back_state_t;

endpackage

// File: hw/rtl/lpht_front.sv
module lpht_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [1:0]                    in_opcode,
  input  logic [7:0]                    in_key_byte,
  input  logic                          in_key_end,
  input  logic [lpht_pkg::VALUE_W-1:0]  in_put_value,
  input  lpht_pkg::queue_status_t       q_status,
  output logic                          busy,
  output logic                          push,
  output lpht_pkg::cmd_t                push_cmd
);

  logic [lpht_pkg::LEN_W-1:0]  cnt_r, cnt_nxt, cnt_step;
  logic [lpht_pkg::HASH_W-1:0] acc_r, acc_nxt, acc_step;
  logic [lpht_pkg::HASH_W-1:0] pow_r, pow_nxt, pow_step;
  lpht_pkg::key_t              keybuf_r, keybuf_nxt, keybuf_step;
  logic                        accept;

  assign busy   = q_status.full;
  assign accept = start && !busy;

  always_comb begin
    cnt_step    = cnt_r;
    acc_step    = acc_r;
    pow_step    = pow_r;
    keybuf_step = keybuf_r;
    if (cnt_r < lpht_pkg::LEN_W'(lpht_pkg::MAX_KEY_LEN)) begin
      keybuf_step[cnt_r[lpht_pkg::IDX_W-1:0]] = in_key_byte;
      acc_step = acc_r + pow_r * lpht_pkg::HASH_W'(in_key_byte);
      pow_step = (pow_r << 5) + pow_r;
      cnt_step = cnt_r + 1'b1;
    end else begin
      cnt_step = lpht_pkg::LEN_W'(lpht_pkg::MAX_KEY_LEN + 1);
    end
  end

  always_comb begin
    cnt_nxt           = cnt_r;
    acc_nxt           = acc_r;
    pow_nxt           = pow_r;
    keybuf_nxt        = keybuf_r;
    push              = 1'b0;
    push_cmd.op       = lpht_pkg::opcode_t'(in_opcode);
    push_cmd.len      = cnt_step;
    push_cmd.too_long = (cnt_step > lpht_pkg::LEN_W'(lpht_pkg::MAX_KEY_LEN));
    push_cmd.acc      = acc_step;
    push_cmd.value    = in_put_value;
    push_cmd.key      = keybuf_step;
    if (accept) begin
      keybuf_nxt = keybuf_step;
      if (in_key_end) begin
        push    = (lpht_pkg::opcode_t'(in_opcode) != lpht_pkg::OP_DISCARD);
        cnt_nxt = '0;
        acc_nxt = '0;
        pow_nxt = lpht_pkg::HASH_W'(1);
      end else begin
        cnt_nxt = cnt_step;
        acc_nxt = acc_step;
        pow_nxt = pow_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      acc_r <= '0;
      pow_r <= lpht_pkg::HASH_W'(1);
    end else begin
      cnt_r <= cnt_nxt;
      acc_r <= acc_nxt;
      pow_r <= pow_nxt;
    end
    keybuf_r <= keybuf_nxt;
  end

endmodule

// File: hw/rtl/lpht_queue.sv
module lpht_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  lpht_pkg::cmd_t          push_cmd,
  input  logic                    pop,
  output lpht_pkg::cmd_t          head,
  output lpht_pkg::queue_status_t q_status
);

  lpht_pkg::cmd_t                 entry_r [lpht_pkg::QUEUE_DEPTH];
  logic [lpht_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [lpht_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign q_status.full  = (cnt_r == lpht_pkg::QCNT_W'(lpht_pkg::QUEUE_DEPTH));
  assign q_status.empty = (cnt_r == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/lpht_back.sv
module lpht_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpht_pkg::queue_status_t       q_status,
  input  lpht_pkg::cmd_t                head,
  output logic                          pop,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [lpht_pkg::VALUE_W-1:0]  out_value_out,
  output logic [lpht_pkg::SLOT_W-1:0]   out_slot
);

  localparam int ADDR_W = lpht_pkg::SLOT_W + lpht_pkg::IDX_W;

  logic [7:0]                  key_mem [lpht_pkg::TABLE_DEPTH * (2 ** lpht_pkg::IDX_W)];
  logic [lpht_pkg::LEN_W-1:0]  len_mem [lpht_pkg::TABLE_DEPTH];
  logic [lpht_pkg::VALUE_W-1:0] val_mem [lpht_pkg::TABLE_DEPTH];

  lpht_pkg::back_state_t        state_r, state_nxt;
  lpht_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [lpht_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  logic [lpht_pkg::SLOT_W-1:0]  count_r, count_nxt;
  logic [lpht_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [lpht_pkg::TABLE_DEPTH-1:0] occ_r, tomb_r;
  logic [7:0]                   byte_q;
  logic [lpht_pkg::LEN_W-1:0]   len_q;
  logic [lpht_pkg::VALUE_W-1:0] val_q;
  logic [lpht_pkg::HASH_W-1:0]  hash;
  logic                         res_valid_r, res_valid_nxt;
  lpht_pkg::status_t            res_status_r, res_status_nxt;
  logic [lpht_pkg::VALUE_W-1:0] res_value_r, res_value_nxt;
  logic [lpht_pkg::SLOT_W-1:0]  res_slot_r, res_slot_nxt;
  logic                         wr_en, set_live, set_tomb;
  logic                         is_put, is_free, last_probe, last_byte, len_eq, byte_eq;
  logic [ADDR_W-1:0]            addr;

  assign hash       = cmd_r.acc * lpht_pkg::GOLDEN_FRAC;
  assign addr       = {slot_r, idx_r};
  assign is_put     = (cmd_r.op == lpht_pkg::OP_PUT);
  assign is_free    = !occ_r[slot_r] || tomb_r[slot_r];
  assign last_probe = (count_r == lpht_pkg::SLOT_W'(lpht_pkg::TABLE_DEPTH - 1));
  assign last_byte  = (idx_r == lpht_pkg::IDX_W'(cmd_r.len - 1'b1));
  assign len_eq     = (len_q == cmd_r.len);
  assign byte_eq    = (byte_q == cmd_r.key[idx_r]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpht_pkg::BK_IDLE: begin
        if (!q_status.empty) state_nxt = lpht_pkg::BK_HASH;
      end
      lpht_pkg::BK_HASH: begin
        state_nxt = cmd_r.too_long ? lpht_pkg::BK_IDLE : lpht_pkg::BK_PROBE;
      end
      lpht_pkg::BK_PROBE: begin
        if (is_put) begin
          if (is_free) state_nxt = lpht_pkg::BK_WRITE;
          else if (last_probe) state_nxt = lpht_pkg::BK_IDLE;
        end else if (!occ_r[slot_r]) begin
          state_nxt = lpht_pkg::BK_IDLE;
        end else if (tomb_r[slot_r]) begin
          if (last_probe) state_nxt = lpht_pkg::BK_IDLE;
        end else begin
          state_nxt = lpht_pkg::BK_LEN_CHK;
        end
      end
      lpht_pkg::BK_LEN_CHK: begin
        if (len_eq) state_nxt = lpht_pkg::BK_BYTE_CHK;
        else state_nxt = last_probe ? lpht_pkg::BK_IDLE : lpht_pkg::BK_PROBE;
      end
      lpht_pkg::BK_BYTE_CHK: begin
        if (!byte_eq) state_nxt = last_probe ? lpht_pkg::BK_IDLE : lpht_pkg::BK_PROBE;
        else if (last_byte) state_nxt = lpht_pkg::BK_IDLE;
        else state_nxt = lpht_pkg::BK_BYTE_WAIT;
      end
      lpht_pkg::BK_BYTE_WAIT: begin
        state_nxt = lpht_pkg::BK_BYTE_CHK;
      end
      lpht_pkg::BK_WRITE: begin
        if (last_byte) state_nxt = lpht_pkg::BK_IDLE;
      end
      default: state_nxt = lpht_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop            = 1'b0;
    cmd_nxt        = cmd_r;
    slot_nxt       = slot_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    wr_en          = 1'b0;
    set_live       = 1'b0;
    set_tomb       = 1'b0;
    res_valid_nxt  = 1'b0;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_slot_nxt   = res_slot_r;
    case (state_r)
      lpht_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          pop     = 1'b1;
          cmd_nxt = head;
        end
      end
      lpht_pkg::BK_HASH: begin
        slot_nxt  = hash[lpht_pkg::HASH_W-1 -: lpht_pkg::SLOT_W];
        count_nxt = '0;
        idx_nxt   = '0;
        if (cmd_r.too_long) begin
          res_valid_nxt  = 1'b1;
          res_status_nxt = lpht_pkg::ST_TOO_LONG;
          res_value_nxt  = '0;
          res_slot_nxt   = '0;
        end
      end
      lpht_pkg::BK_PROBE: begin
        if (is_put) begin
          if (!is_free) begin
            slot_nxt  = slot_r + 1'b1;
            count_nxt = count_r + 1'b1;
            if (last_probe) begin
              res_valid_nxt  = 1'b1;
              res_status_nxt = lpht_pkg::ST_TABLE_FULL;
              res_value_nxt  = '0;
              res_slot_nxt   = '0;
            end
          end
        end else if (!occ_r[slot_r] || (tomb_r[slot_r] && last_probe)) begin
          res_valid_nxt  = 1'b1;
          res_status_nxt = lpht_pkg::ST_NOT_FOUND;
          res_value_nxt  = '0;
          res_slot_nxt   = '0;
        end else if (tomb_r[slot_r]) begin
          slot_nxt  = slot_r + 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      lpht_pkg::BK_LEN_CHK, lpht_pkg::BK_BYTE_CHK: begin
        if ((state_r == lpht_pkg::BK_LEN_CHK) ? !len_eq : !byte_eq) begin
          slot_nxt  = slot_r + 1'b1;
          count_nxt = count_r + 1'b1;
          idx_nxt   = '0;
          if (last_probe) begin
            res_valid_nxt  = 1'b1;
            res_status_nxt = lpht_pkg::ST_NOT_FOUND;
            res_value_nxt  = '0;
            res_slot_nxt   = '0;
          end
        end else if (state_r == lpht_pkg::BK_BYTE_CHK) begin
          if (last_byte) begin
            res_valid_nxt  = 1'b1;
            res_status_nxt = lpht_pkg::ST_OK;
            res_value_nxt  = val_q;
            res_slot_nxt   = slot_r;
            set_tomb       = (cmd_r.op == lpht_pkg::OP_REMOVE);
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      lpht_pkg::BK_BYTE_WAIT: begin
      end
      lpht_pkg::BK_WRITE: begin
        wr_en   = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (last_byte) begin
          set_live       = 1'b1;
          res_valid_nxt  = 1'b1;
          res_status_nxt = lpht_pkg::ST_OK;
          res_value_nxt  = '0;
          res_slot_nxt   = slot_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpht_pkg::BK_IDLE;
      occ_r       <= '0;
      tomb_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      if (set_live) begin
        occ_r[slot_r]  <= 1'b1;
        tomb_r[slot_r] <= 1'b0;
      end
      if (set_tomb) begin
        tomb_r[slot_r] <= 1'b1;
      end
    end
    cmd_r        <= cmd_nxt;
    slot_r       <= slot_nxt;
    count_r      <= count_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_slot_r   <= res_slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[addr]   <= cmd_r.key[idx_r];
      len_mem[slot_r] <= cmd_r.len;
      val_mem[slot_r] <= cmd_r.value;
    end
    byte_q <= key_mem[addr];
    len_q  <= len_mem[slot_r];
    val_q  <= val_mem[slot_r];
  end

  assign out_valid     = res_valid_r;
  assign out_status    = res_status_r;
  assign out_value_out = res_value_r;
  assign out_slot      = res_slot_r;

endmodule

// File: hw/rtl/linear_probe_hash_table_top.sv
// Channel   Direction  Handshake                 Payload
// input     in         start high, busy low      in_opcode, in_key_byte, in_key_end,
//                                                in_put_value
// result    out        out_valid, one cycle      out_status, out_value_out, out_slot
//
// Key bytes are taken one per cycle while busy is low; the last byte queues an operation
// for the back end unless the opcode is discard. An operation is hashed and then probes
// slots in turn; a live slot gets a length check and, if the length matches, a compare of
// its key bytes. A put copies the key into the first free slot. At most 64 slots are
// probed. busy is high while two operations wait in the queue. Reset is synchronous and
// empties the table at once. Results cannot be held off and appear for exactly one cycle.
module linear_probe_hash_table_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_opcode,
  input  logic [7:0]                    in_key_byte,
  input  logic                          in_key_end,
  input  logic [lpht_pkg::VALUE_W-1:0]  in_put_value,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [lpht_pkg::VALUE_W-1:0]  out_value_out,
  output logic [lpht_pkg::SLOT_W-1:0]   out_slot
);

  lpht_pkg::queue_status_t q_status;
  lpht_pkg::cmd_t          push_cmd, head;
  logic                    push, pop;

  lpht_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_opcode    (in_opcode),
    .in_key_byte  (in_key_byte),
    .in_key_end   (in_key_end),
    .in_put_value (in_put_value),
    .q_status     (q_status),
    .busy         (busy),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  lpht_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  lpht_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_status      (q_status),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .out_slot      (out_slot)
  );

  // A result transaction is never followed directly by another one.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("back-to-back result transactions");

  // Failed operations report neither a value nor a slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != lpht_pkg::ST_OK) |-> (out_slot == '0 && out_value_out == '0))
    else $error("failed operation carries a value or slot");

  // Nothing is reported in the cycle after reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result transaction straight after reset");

endmodule
